/* hw/rtl/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the LRU key-value cache: field widths,
// request codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int FIELD_W    = 16;
  localparam int CFG_W      = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;
  localparam int OUT_USER_W = 2;

  localparam int USER_FOUND   = 0;
  localparam int USER_EVICTED = 1;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_PUT = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_UPDATE,
    ST_AGE,
    ST_AGE_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic update;
    logic age_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_age;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/lkv_ctrl.sv */
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer of the cache: takes a request, runs the tag scan, the update step
// and the age sweep (not on a get miss), then fills the output register.
// ----------------------------------------------------------------------------
module lkv_ctrl
  import lkv_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.idx_last) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = status.need_age ? ST_AGE : ST_DONE;
      end
      ST_AGE: begin
        if (status.idx_last) state_nxt = ST_AGE_END;
      end
      ST_AGE_END: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_AGE: begin
        cmd.age_step = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/lkv_dpath.sv */
// ----------------------------------------------------------------------------
// lkv_dpath
// Datapath of the cache: key, value and age memories, valid bits, occupancy,
// scan trackers for hit, victim and free slot, and the output register.
// ----------------------------------------------------------------------------
module lkv_dpath
  import lkv_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > CFG_W) ? CW : CFG_W;

  logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [IW-1:0]          age_mem [CAPACITY];
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [IW-1:0]          age_q;

  logic [CFG_W-1:0]       cap_r;
  logic                   req_put_r;
  logic [KEY_WIDTH-1:0]   req_key_r;
  logic [VALUE_WIDTH-1:0] req_val_r;

  logic [IW-1:0]          idx_r;
  logic [IW-1:0]          pend_idx_r;
  logic                   scan_pend_r;
  logic                   age_pend_r;

  logic [CAPACITY-1:0]    valid_r;
  logic [CW-1:0]          used_r;

  logic                   hit_r;
  logic [IW-1:0]          hit_idx_r;
  logic [IW-1:0]          hit_age_r;
  logic                   any_r;
  logic [IW-1:0]          best_idx_r;
  logic [IW-1:0]          best_age_r;
  logic [KEY_WIDTH-1:0]   best_key_r;
  logic                   free_ok_r;
  logic [IW-1:0]          free_idx_r;

  logic [IW-1:0]          tgt_idx_r;
  logic                   mode_hit_r;
  logic                   res_found_r;
  logic                   res_get_hit_r;
  logic                   res_evicted_r;
  logic [FIELD_W-1:0]     res_evk_r;

  logic                   out_valid_r;
  logic [OUT_USER_W-1:0]  out_user_r;
  logic [OUT_DATA_W-1:0]  out_data_r;

  logic [EW-1:0]          eff_cap;
  logic                   is_full;
  logic                   ins;
  logic                   evict;
  logic [IW-1:0]          slot;
  logic                   scan_valid;
  logic                   scan_match;
  logic [IW-1:0]          age_new;
  logic                   idx_last;
  logic [FIELD_W-1:0]     read_value;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(cap_r) > EW'(CAPACITY)) begin
      eff_cap = EW'(CAPACITY);
    end else begin
      eff_cap = EW'(cap_r);
    end
  end

  assign idx_last   = (idx_r == IW'(CAPACITY - 1));
  assign is_full    = (EW'(used_r) >= eff_cap);
  assign ins        = !hit_r && (req_put_r == REQ_PUT);
  assign evict      = ins && is_full && any_r;
  assign slot       = evict ? best_idx_r : free_idx_r;
  assign scan_valid = valid_r[pend_idx_r];
  assign scan_match = scan_valid && (key_q == req_key_r);
  assign read_value = res_get_hit_r ? FIELD_W'(val_q) : '0;

  always_comb begin
    if (pend_idx_r == tgt_idx_r) begin
      age_new = '0;
    end else if (mode_hit_r && !(age_q < hit_age_r)) begin
      age_new = age_q;
    end else begin
      age_new = age_q + IW'(1);
    end
  end

  assign status.idx_last = idx_last;
  assign status.need_age = hit_r || (req_put_r == REQ_PUT);
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (cmd.scan_step || cmd.age_step) begin
      age_q <= age_mem[idx_r];
    end
    if (age_pend_r) begin
      age_mem[pend_idx_r] <= age_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      key_q <= key_mem[idx_r];
    end
    if (cmd.update && ins) begin
      key_mem[slot] <= req_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && hit_r && (req_put_r == REQ_GET)) begin
      val_q <= val_mem[hit_idx_r];
    end
    if (cmd.update && (req_put_r == REQ_PUT)) begin
      val_mem[hit_r ? hit_idx_r : slot] <= req_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CFG_RESET;
      idx_r       <= '0;
      scan_pend_r <= 1'b0;
      age_pend_r  <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      hit_r       <= 1'b0;
      any_r       <= 1'b0;
      free_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      scan_pend_r <= cmd.scan_step;
      age_pend_r  <= cmd.age_step;
      if (cmd.load_req) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        any_r     <= 1'b0;
        free_ok_r <= 1'b0;
      end else if (cmd.scan_step || cmd.age_step) begin
        idx_r <= idx_last ? '0 : idx_r + IW'(1);
      end
      if (scan_pend_r) begin
        if (scan_match && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (scan_valid && (!any_r || (age_q > best_age_r))) begin
          any_r <= 1'b1;
        end
        if (!scan_valid && !free_ok_r) begin
          free_ok_r <= 1'b1;
        end
      end
      if (cmd.update && ins) begin
        valid_r[slot] <= 1'b1;
        if (!evict) begin
          used_r <= used_r + CW'(1);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_put_r <= in_tuser;
      req_key_r <= KEY_WIDTH'(in_tdata[FIELD_W-1:0]);
      req_val_r <= VALUE_WIDTH'(in_tdata[IN_DATA_W-1:FIELD_W]);
    end
    if (cmd.scan_step || cmd.age_step) begin
      pend_idx_r <= idx_r;
    end
    if (scan_pend_r) begin
      if (scan_match && !hit_r) begin
        hit_idx_r <= pend_idx_r;
        hit_age_r <= age_q;
      end
      if (scan_valid && (!any_r || (age_q > best_age_r))) begin
        best_idx_r <= pend_idx_r;
        best_age_r <= age_q;
        best_key_r <= key_q;
      end
      if (!scan_valid && !free_ok_r) begin
        free_idx_r <= pend_idx_r;
      end
    end
    if (cmd.update) begin
      tgt_idx_r     <= hit_r ? hit_idx_r : slot;
      mode_hit_r    <= hit_r;
      res_found_r   <= hit_r;
      res_get_hit_r <= hit_r && (req_put_r == REQ_GET);
      res_evicted_r <= evict;
      res_evk_r     <= evict ? FIELD_W'(best_key_r) : '0;
    end
    if (cmd.out_load) begin
      out_user_r <= {res_evicted_r, res_found_r};
      out_data_r <= {res_evk_r, read_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

/* hw/rtl/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request is in work at a time. A request scans the entries one per
// cycle through the key and age memories, makes its decision in the update
// step, then sweeps the age memory once more, one entry per cycle, to reorder
// the recency. A get miss skips the age sweep. A finished result waits in the
// output register while the next request is accepted. The capacity register
// may be written at any time the cache is idle; a value of zero acts as one
// and values above CAPACITY act as CAPACITY.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: lookup_key[15:0], write_value[31:16].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: req_type.
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: read_value[15:0], evicted_key[31:16].
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: found, evicted.
  output logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lkv_dpath #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/lkv_checker.sv */
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker
  import lkv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Only one request is in work, so acceptance closes the input.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while one is in work");

  // An eviction only happens on a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_EVICTED] |-> !out_tuser[USER_FOUND])
    else $error("eviction reported together with a hit");

  // A miss returns no value.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[USER_FOUND] |-> out_tdata[FIELD_W-1:0] == '0)
    else $error("value returned on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
